@@ hdl/gwm_pkg.sv @@
// ----------------------------------------------------------------------------
// gwm_pkg: shared definitions for the glob wildcard matcher
// Character codes, register indexes, widths and the item type that the
// matcher step logic and the top level both use.
// ----------------------------------------------------------------------------
package gwm_pkg;

   localparam int MAX_PATTERN_DEF = 32;   // default pattern capacity
   localparam int STORED_BYTES    = 32;   // pattern bytes held in registers
   localparam int LEN_W           = 6;    // width of pattern_length
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 64;

   localparam logic [7:0] STAR_CHAR = 8'h2A;   // '*'
   localparam logic [7:0] ANY_CHAR  = 8'h3F;   // '?'

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES_3 = 3'd4;

   typedef struct packed {
      logic [7:0] name_char;
      logic       last;
      logic       empty_req;
   } item_type;

endpackage

@@ hdl/gwm_nfa.sv @@
// ----------------------------------------------------------------------------
// gwm_nfa: one step of the wildcard automaton
// Closes the live-position vector over stars, advances it by one name byte
// and reports whether the full pattern is reached at the end of a name.
// ----------------------------------------------------------------------------
module gwm_nfa #(
   parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF,
   localparam int EFF_MAX    = (MAX_PATTERN < gwm_pkg::STORED_BYTES) ?
                               MAX_PATTERN : gwm_pkg::STORED_BYTES,
   localparam int VEC_W      = EFF_MAX + 1
) (
   input  gwm_pkg::item_type                        item,
   input  logic [gwm_pkg::LEN_W-1:0]                pattern_length,
   input  logic [8*gwm_pkg::STORED_BYTES-1:0]       pattern_bytes,
   input  logic [VEC_W-1:0]                         live_vec,
   output logic [VEC_W-1:0]                         next_live,
   output logic                                     matched
);
   import gwm_pkg::*;

   localparam int LW     = $clog2(VEC_W);
   localparam int LEVELS = $clog2(VEC_W);

   logic [LW-1:0]      len_eff;
   logic [EFF_MAX-1:0] act_v;
   logic [EFF_MAX-1:0] star_v;
   logic [EFF_MAX-1:0] hit_v;
   logic [EFF_MAX-1:0] keep_v;
   logic [EFF_MAX-1:0] adv_v;
   logic [VEC_W-1:0]   pass_v;
   logic [VEC_W-1:0]   cur_v;
   logic [VEC_W-1:0]   step_v;
   logic [VEC_W-1:0]   done_v;

   // Star closure as a parallel prefix: a live bit runs forward through
   // every consecutive star, like a carry through propagate bits.
   function automatic logic [VEC_W-1:0] close_stars(input logic [VEC_W-1:0] gen,
                                                    input logic [VEC_W-1:0] pass);
      logic [VEC_W-1:0] g;
      logic [VEC_W-1:0] p;
      g = gen;
      p = pass;
      for (int d = 0; d < LEVELS; d++) begin
         g = g | (p & (g << (1 << d)));
         p = p & (p << (1 << d));
      end
      return g;
   endfunction

   assign len_eff = (pattern_length > LEN_W'(EFF_MAX)) ? LW'(EFF_MAX)
                                                       : pattern_length[LW-1:0];

   for (genvar i = 0; i < EFF_MAX; i++) begin : g_pos
      logic [7:0] pat_byte;
      assign pat_byte  = pattern_bytes[8*i +: 8];
      assign act_v[i]  = LW'(i) < len_eff;
      assign star_v[i] = act_v[i] && (pat_byte == STAR_CHAR);
      assign hit_v[i]  = act_v[i] && (pat_byte != STAR_CHAR) &&
                         ((pat_byte == ANY_CHAR) || (pat_byte == item.name_char));
   end

   assign pass_v = {star_v, 1'b0};
   assign cur_v  = close_stars(live_vec, pass_v);

   // A star keeps its position; a literal or '?' hit moves one forward.
   assign keep_v    = cur_v[EFF_MAX-1:0] & star_v;
   assign adv_v     = cur_v[EFF_MAX-1:0] & hit_v;
   assign step_v    = {1'b0, keep_v} | {adv_v, 1'b0};
   assign done_v    = close_stars(step_v, pass_v);
   assign next_live = step_v;
   assign matched   = item.empty_req ? cur_v[len_eff] : done_v[len_eff];

endmodule

@@ hdl/glob_wildcard_matcher.sv @@
// ----------------------------------------------------------------------------
// glob_wildcard_matcher: streaming file-name glob matcher
// Matches a name, one byte per beat, against a '*' / '?' pattern held in
// registers and returns one match bit at the end of each name.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                           ends a name
//   req_*     in         tdata=name_char tlast tuser=empty  tlast or tuser
//   rsp_*     out        tdata[0]=matched                   every beat
//   csr_*     in         index 0..4, 64-bit data            -
//
// One name byte per cycle unless a beat ending a name waits on an unread
// result; an accepted request beat is held in the step register, and its
// result is then registered in the response register.
// The live-position update (star closure, compare, shift) is combinational
// and sets that rate. Reset clears the pattern and leaves only position zero live.
// A stalled response holds; request beats that end no name keep flowing,
// and one ending a name waits only while an earlier result is still unread.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher #(
   parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,    // [7:0] name_char
   input  logic                            req_tlast,
   input  logic                            req_tuser,    // [0] empty_req
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,    // [0] matched, [7:1] zero
   // configuration channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gwm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gwm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import gwm_pkg::*;

   localparam int EFF_MAX = (MAX_PATTERN < STORED_BYTES) ? MAX_PATTERN : STORED_BYTES;
   localparam int VEC_W   = EFF_MAX + 1;

   // configuration registers
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [8*STORED_BYTES-1:0] pat_ff, pat_in;

   // step register
   logic     s1_valid_ff, s1_valid_in;
   item_type item_ff, item_in;

   // live positions, stored before star closure
   logic [VEC_W-1:0] live_ff, live_in;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_match_ff, rsp_match_in;

   logic             req_fire;
   logic             eoi;
   logic             s1_adv;
   logic [VEC_W-1:0] step_live;
   logic             step_match;

   // Configuration: always ready, unknown indexes drop the write.
   assign csr_ready = 1'b1;

   always_comb begin
      len_in = len_ff;
      pat_in = pat_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH:  len_in = csr_data[LEN_W-1:0];
            CSR_PATTERN_BYTES_0: pat_in[0*CSR_DATA_W +: CSR_DATA_W] = csr_data;
            CSR_PATTERN_BYTES_1: pat_in[1*CSR_DATA_W +: CSR_DATA_W] = csr_data;
            CSR_PATTERN_BYTES_2: pat_in[2*CSR_DATA_W +: CSR_DATA_W] = csr_data;
            CSR_PATTERN_BYTES_3: pat_in[3*CSR_DATA_W +: CSR_DATA_W] = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Only a beat that ends a name needs room in the result register.
   assign eoi        = item_ff.last || item_ff.empty_req;
   assign s1_adv     = s1_valid_ff && (!eoi || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   gwm_nfa #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_nfa (
      .item           (item_ff),
      .pattern_length (len_ff),
      .pattern_bytes  (pat_ff),
      .live_vec       (live_ff),
      .next_live      (step_live),
      .matched        (step_match)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      item_in     = item_ff;
      if (req_fire) begin
         s1_valid_in       = 1'b1;
         item_in.name_char = req_tdata;
         item_in.last      = req_tlast;
         item_in.empty_req = req_tuser;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      // Advance the live vector; restart at position zero after a name ends.
      live_in = live_ff;
      if (s1_adv) begin
         live_in = eoi ? VEC_W'(1) : step_live;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_match_in = rsp_match_ff;
      if (s1_adv && eoi) begin
         rsp_valid_in = 1'b1;
         rsp_match_in = step_match;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         pat_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         live_ff      <= VEC_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         pat_ff       <= pat_in;
         s1_valid_ff  <= s1_valid_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      rsp_match_ff <= rsp_match_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_match_ff};

   // A beat that ends a name always loads the result register.
   a_eoi_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && eoi) |=> rsp_valid_ff)
      else $error("end-of-name beat did not load a result");

   // After a name ends only position zero stays stored.
   a_eoi_restarts: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && eoi) |=> (live_ff == VEC_W'(1)))
      else $error("live vector not restarted after end of name");

   // A held step register keeps its beat untouched.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(item_ff) && $stable(live_ff)))
      else $error("stalled step register changed");

   // Reset leaves only position zero live.
   a_reset_live: assert property (@(posedge clock)
      $past(reset) |-> (live_ff == VEC_W'(1)))
      else $error("live vector wrong after reset");

endmodule

@@ sim/tb_glob_wildcard_matcher.sv @@
// ----------------------------------------------------------------------------
// tb_glob_wildcard_matcher: self-checking bench for the glob wildcard matcher
// Streams file names one byte per beat against patterns written through the
// register channel. A built-in model of the live-position set predicts each
// match bit; every response beat is compared with the oldest prediction.
// A short scripted part covers the corner cases, then random names follow.
// ----------------------------------------------------------------------------
module tb_glob_wildcard_matcher;

   import gwm_pkg::*;

   localparam int RESET_CYCLES    = 7;
   localparam int SETTLE_CYCLES   = 8;       // lets the step and response registers empty
   localparam int HOLD_OFF_CYCLES = 300;     // long receiver stall to back up the block
   localparam int BEATS_PER_PHASE = 96;
   localparam int PHASES          = 5;       // patterns per idling regime
   localparam int CYCLE_LIMIT     = 400000;

   // Scripted stimulus: either a pattern to program or one request beat.
   // pin marks rows whose match bit is obvious and typed in as pin_match.
   typedef struct packed {
      logic             is_pattern;
      logic [LEN_W-1:0] len;
      logic [255:0]     text;
      logic [7:0]       name_char;
      logic             name_last;
      logic             name_empty;
      logic             pin;
      logic             pin_match;
   } script_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;    // [7:0] name_char
   logic                   req_tlast  = 1'b0;
   logic                   req_tuser  = 1'b0;  // [0] empty_req
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;          // [0] matched, [7:1] zero
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // Model state: a copy of the pattern registers and the live-position set
   logic [LEN_W-1:0]       pat_len   = '0;
   logic [255:0]           pat_bytes = '0;
   logic [STORED_BYTES:0]  live_set  = 1;

   logic                   expected_matches[$];  // match bits in order of name end
   logic [1:0]             pinned_matches[$];    // {pin, pin_match} per name end
   logic [7:0]             name_buf[$];          // name under construction
   script_row_type         script[$];

   int                     failures         = 0;
   int                     beats_sent       = 0;
   int                     cycle_count      = 0;
   int                     send_idle_pct    = 0;
   int                     recv_idle_pct    = 0;
   logic                   hold_off_pending = 1'b0;

   glob_wildcard_matcher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model of the matcher
   // ------------------------------------------------------------------------

   // Pattern bytes that take part: capped by capacity and by storage
   function automatic int glob_span(input logic [LEN_W-1:0] len);
      int n;
      n = len;
      if (n > MAX_PATTERN_DEF) n = MAX_PATTERN_DEF;
      if (n > STORED_BYTES) n = STORED_BYTES;
      return n;
   endfunction

   // A live star also makes the position after it live; ascending order
   // lets a run of stars propagate in one pass.
   function automatic logic [STORED_BYTES:0] star_closure(input logic [STORED_BYTES:0] v,
                                                         input int span);
      for (int i = 0; i < span; i++) begin
         if (v[i] && pat_bytes[8*i +: 8] == STAR_CHAR) v[i+1] = 1'b1;
      end
      return v;
   endfunction

   // Track register writes and request beats, predict, and check responses.
   // All sampling happens at the edge, before this edge's updates land.
   always @(posedge clock) begin
      logic [STORED_BYTES:0] now_live;
      logic [STORED_BYTES:0] next_live;
      logic [7:0]            pat_char;
      logic [1:0]            pin;
      logic                  want;
      int                    span;
      if (reset) begin
         pat_len   = '0;
         pat_bytes = '0;
         live_set  = 1;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LENGTH:  pat_len            = csr_data[LEN_W-1:0];
               CSR_PATTERN_BYTES_0: pat_bytes[63:0]    = csr_data;
               CSR_PATTERN_BYTES_1: pat_bytes[127:64]  = csr_data;
               CSR_PATTERN_BYTES_2: pat_bytes[191:128] = csr_data;
               CSR_PATTERN_BYTES_3: pat_bytes[255:192] = csr_data;
               default: ;   // drop writes to unmapped indexes
            endcase
         end
         if (req_tvalid && req_tready) begin
            span     = glob_span(pat_len);
            now_live = star_closure(live_set, span);
            if (req_tuser) begin
               // empty request: end the name here, the byte is not consumed
               expected_matches.insert(expected_matches.size(), now_live[span]);
               live_set = 1;
            end else begin
               next_live = '0;
               for (int i = 0; i < span; i++) begin
                  pat_char = pat_bytes[8*i +: 8];
                  if (now_live[i]) begin
                     if (pat_char == STAR_CHAR) next_live[i] = 1'b1;
                     else if (pat_char == ANY_CHAR || pat_char == req_tdata)
                        next_live[i+1] = 1'b1;
                  end
               end
               if (req_tlast) begin
                  next_live = star_closure(next_live, span);
                  expected_matches.insert(expected_matches.size(), next_live[span]);
                  live_set = 1;
               end else begin
                  live_set = next_live;
               end
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_matches.size() == 0) begin
               $display("%0t: response beat with nothing expected, expected none, got %0h",
                        $time, rsp_tdata);
               failures++;
            end else begin
               want = expected_matches.pop_front();
               pin  = (pinned_matches.size() != 0) ? pinned_matches.pop_front() : 2'b00;
               if (rsp_tdata !== {7'b0, want}) begin
                  $display("%0t: match mismatch, expected %0h, got %0h",
                           $time, {7'b0, want}, rsp_tdata);
                  failures++;
               end else if (pin[1] && rsp_tdata[0] !== pin[0]) begin
                  $display("%0t: scripted match mismatch, expected %0h, got %0h",
                           $time, pin[0], rsp_tdata[0]);
                  failures++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      logic hold_off_taken;
      hold_off_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: end the run with an error when the cycle limit is reached
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[glob_wildcard_matcher] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic logic [255:0] pack_text(input string s);
      logic [255:0] v;
      v = '0;
      for (int i = 0; i < s.len() && i < STORED_BYTES; i++) v[8*i +: 8] = s[i];
      return v;
   endfunction

   // Mostly a small alphabet so names hit the pattern; sometimes any byte
   function automatic logic [7:0] random_name_char();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 75) return "a" + 8'($urandom_range(2));
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] random_pattern_char();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 35) return "a" + 8'($urandom_range(1));
      if (pick < 60) return STAR_CHAR;
      if (pick < 80) return ANY_CHAR;
      return 8'($urandom_range(255));
   endfunction

   task automatic add_beat(input logic [7:0] ch, input logic name_last,
                           input logic name_empty, input logic pin, input logic pin_match);
      script_row_type row;
      row            = '0;
      row.name_char  = ch;
      row.name_last  = name_last;
      row.name_empty = name_empty;
      row.pin        = pin;
      row.pin_match  = pin_match;
      script.insert(script.size(), row);
   endtask

   task automatic add_name(input string s, input logic pin, input logic pin_match);
      for (int i = 0; i < s.len(); i++)
         add_beat(s[i], i == s.len() - 1, 1'b0, pin, pin_match);
   endtask

   task automatic add_pattern(input string s, input logic [LEN_W-1:0] len);
      script_row_type row;
      row            = '0;
      row.is_pattern = 1'b1;
      row.len        = len;
      row.text       = pack_text(s);
      script.insert(script.size(), row);
   endtask

   // Offer one request beat after a random gap; return on acceptance with
   // tvalid still high so back-to-back beats need no extra edge.
   task automatic push_beat(input logic [7:0] ch, input logic name_last,
                            input logic name_empty, input logic pin, input logic pin_match);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (name_last || name_empty)
         pinned_matches.insert(pinned_matches.size(), {pin, pin_match});
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= name_last;
      req_tuser  <= name_empty;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   // Drop tvalid, wait for every outstanding match bit, then let the
   // pipeline empty of beats that end no name.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_beat(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Write every register, plus one write to an unmapped index
   task automatic program_pattern(input logic [LEN_W-1:0] len, input logic [255:0] text);
      csr_beat(CSR_PATTERN_BYTES_0, text[63:0]);
      csr_beat(CSR_PATTERN_BYTES_1, text[127:64]);
      csr_beat(CSR_PATTERN_BYTES_2, text[191:128]);
      csr_beat(CSR_PATTERN_BYTES_3, text[255:192]);
      // upper bits of the length write carry junk that must be ignored
      csr_beat(CSR_PATTERN_LENGTH, {$urandom, 26'($urandom), len});
      csr_beat(CSR_PATTERN_BYTES_3 + CSR_IDX_W'($urandom_range(3, 1)), {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   // Fill name_buf with a name that the given pattern accepts
   task automatic spell_name(input logic [LEN_W-1:0] len, input logic [255:0] text);
      logic [7:0] p;
      int         span;
      name_buf.delete();
      span = glob_span(len);
      for (int i = 0; i < span; i++) begin
         p = text[8*i +: 8];
         if (p == STAR_CHAR)
            repeat ($urandom_range(3)) name_buf.insert(name_buf.size(), random_name_char());
         else if (p == ANY_CHAR) name_buf.insert(name_buf.size(), random_name_char());
         else name_buf.insert(name_buf.size(), p);
      end
   endtask

   // Send name_buf; end it with tlast, or now and then with an empty beat
   task automatic send_name();
      int          n;
      int unsigned mode;
      n    = name_buf.size();
      mode = $urandom_range(99);
      if (n == 0) begin
         push_beat(random_name_char(), 1'($urandom_range(1)), 1'b1, 1'b0, 1'b0);
         return;
      end
      for (int k = 0; k < n; k++)
         push_beat(name_buf[k], k == n - 1 && mode >= 10, k == n - 1 && mode >= 95,
                   1'b0, 1'b0);
      if (mode < 10)
         push_beat(random_name_char(), 1'($urandom_range(1)), 1'b1, 1'b0, 1'b0);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [LEN_W-1:0] len;
      logic [255:0]     text;
      int unsigned      pick;
      int               phase_start;

      // empty pattern after reset: only the empty name matches
      add_beat(8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
      add_name("a", 1'b1, 1'b0);
      // literal, any-char and trailing star
      add_pattern("a?c*", 4);
      add_name("abc", 1'b0, 1'b0);
      add_name("abcxy", 1'b0, 1'b0);
      // empty request mid-name, with tlast also set: the byte is not consumed
      add_beat("a", 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat("b", 1'b1, 1'b1, 1'b0, 1'b0);
      // zero pattern byte as a literal, matched by a zero name byte
      add_pattern("z", 2);
      add_beat("z", 1'b0, 1'b0, 1'b0, 1'b0);
      add_beat(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
      // longest length field over all-star storage: anything matches
      add_pattern("********************************", 63);
      add_beat(8'hFF, 1'b0, 1'b1, 1'b1, 1'b1);
      add_beat(8'hFF, 1'b1, 1'b0, 1'b1, 1'b1);
      // pattern change in the middle of a name keeps the live set
      add_pattern("?", 1);
      add_beat("q", 1'b0, 1'b0, 1'b0, 1'b0);
      add_pattern("??", 2);
      add_beat("r", 1'b1, 1'b0, 1'b0, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: walk the script
      foreach (script[r]) begin
         if (script[r].is_pattern) begin
            settle();
            program_pattern(script[r].len, script[r].text);
         end else begin
            push_beat(script[r].name_char, script[r].name_last, script[r].name_empty,
                      script[r].pin, script[r].pin_match);
         end
      end

      // Random part: three idling regimes, a few patterns in each
      for (int regime = 0; regime < 3; regime++) begin
         for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            send_idle_pct = (regime == 0) ? 20 : (regime == 1) ? 74 : 0;
            recv_idle_pct = (regime == 0) ? 74 : (regime == 1) ? 20 : 0;

            pick = $urandom_range(99);
            if (pick < 5) len = '0;
            else if (pick < 80) len = LEN_W'($urandom_range(10, 1));
            else if (pick < 92) len = LEN_W'($urandom_range(STORED_BYTES, 11));
            else len = LEN_W'($urandom_range(63, STORED_BYTES + 1));
            for (int i = 0; i < STORED_BYTES; i++) text[8*i +: 8] = random_pattern_char();
            program_pattern(len, text);

            // no idling: hold the receiver off so the block backs up
            if (regime == 2 && ph == 0) hold_off_pending = 1'b1;

            phase_start = beats_sent;
            while (beats_sent - phase_start < BEATS_PER_PHASE) begin
               spell_name(len, text);
               pick = $urandom_range(99);
               if (pick >= 45 && pick < 75) begin
                  // break a well-formed name
                  if (name_buf.size() > 0 && pick < 60)
                     name_buf[$urandom_range(name_buf.size() - 1)] = random_name_char();
                  else if (name_buf.size() > 0 && pick < 68)
                     void'(name_buf.pop_back());
                  else
                     name_buf.insert(name_buf.size(), random_name_char());
               end else if (pick >= 75) begin
                  name_buf.delete();
                  repeat ($urandom_range(8))
                     name_buf.insert(name_buf.size(), random_name_char());
               end
               send_name();
            end

            // sometimes leave a name open across the next pattern change
            if ($urandom_range(3) == 0)
               repeat ($urandom_range(3, 1))
                  push_beat(random_name_char(), 1'b0, 1'b0, 1'b0, 1'b0);
         end
      end

      settle();
      if (failures == 0) begin
         $display("[glob_wildcard_matcher] OK");
      end else begin
         $display("[glob_wildcard_matcher] ERROR");
      end
      $finish;
   end

endmodule
